// ===== design/tlvs_pkg.sv =====
// ----------------------------------------------------------------------------
// TLV record search package
// Shared constants, parser phase and verdict codes, and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package tlvs_pkg;

    localparam int IMAGE_BYTES  = 256;
    localparam int HEADER_BYTES = 4;
    localparam int LEFT_W       = $clog2(IMAGE_BYTES);
    localparam int POS_W        = LEFT_W + 1;
    localparam int SUM_W        = POS_W + 1;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_VALUE  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_PAST_END  = 3'd4;

    typedef struct packed {
        logic       valid;
        logic [7:0] value;
        logic       value_valid;
        logic       scan_done;
        logic [2:0] status;
    } result_t;

endpackage

`default_nettype wire

// ===== design/tlvs_parser.sv =====
// ----------------------------------------------------------------------------
// TLV record search parser
// Holds the scan state and turns one image byte into zero or one result.
// ----------------------------------------------------------------------------
`default_nettype none

module tlvs_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [15:0]         search_type,
    input  wire logic                step,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_first,
    output tlvs_pkg::result_t        result
);

    logic [2:0]                    phase_reg, phase_next;
    logic [tlvs_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [23:0]                   hdr_reg, hdr_next;
    logic [tlvs_pkg::LEFT_W-1:0]   left_reg, left_next;
    logic [1:0]                    hcnt_reg, hcnt_next;

    logic [2:0]                    phase_cur;
    logic [tlvs_pkg::POS_W-1:0]    pos_cur;
    logic [23:0]                   hdr_cur;
    logic [tlvs_pkg::LEFT_W-1:0]   left_cur;
    logic [1:0]                    hcnt_cur;
    logic [31:0]                   hdr_full;
    logic [15:0]                   rec_type;
    logic [15:0]                   rec_len;
    logic [tlvs_pkg::LEFT_W-1:0]   len_short;
    logic [tlvs_pkg::SUM_W-1:0]    value_end;
    logic [tlvs_pkg::SUM_W-1:0]    next_end;
    logic [tlvs_pkg::LEFT_W-1:0]   left_dec;

    always_comb begin
        phase_cur = phase_reg;
        pos_cur   = pos_reg;
        hdr_cur   = hdr_reg;
        left_cur  = left_reg;
        hcnt_cur  = hcnt_reg;
        if (in_first) begin
            phase_cur = tlvs_pkg::PH_HEADER;
            pos_cur   = '0;
            hdr_cur   = '0;
            left_cur  = '0;
            hcnt_cur  = '0;
        end

        hdr_full  = {hdr_cur, in_byte};
        rec_type  = hdr_full[31:16];
        rec_len   = hdr_full[15:0];
        len_short = rec_len[tlvs_pkg::LEFT_W-1:0];
        value_end = tlvs_pkg::SUM_W'(pos_cur) + tlvs_pkg::SUM_W'(1)
                  + tlvs_pkg::SUM_W'(len_short);
        next_end  = value_end + tlvs_pkg::SUM_W'(tlvs_pkg::HEADER_BYTES);
        left_dec  = left_cur - tlvs_pkg::LEFT_W'(1);

        phase_next = phase_cur;
        pos_next   = pos_cur;
        hdr_next   = hdr_cur;
        left_next  = left_cur;
        hcnt_next  = hcnt_cur;
        result     = '0;

        if (in_first && (tlvs_pkg::IMAGE_BYTES < tlvs_pkg::HEADER_BYTES)) begin
            phase_next       = tlvs_pkg::PH_DONE;
            result.valid     = 1'b1;
            result.scan_done = 1'b1;
            result.status    = tlvs_pkg::ST_NOT_FOUND;
        end else begin
            unique case (phase_cur)
                tlvs_pkg::PH_HEADER: begin
                    hdr_next = hdr_full[23:0];
                    pos_next = pos_cur + tlvs_pkg::POS_W'(1);
                    if (hcnt_cur != 2'd3) begin
                        hcnt_next = hcnt_cur + 2'd1;
                    end else begin
                        hcnt_next = '0;
                        if (rec_len > 16'(tlvs_pkg::IMAGE_BYTES - 1)) begin
                            phase_next       = tlvs_pkg::PH_DONE;
                            result.valid     = 1'b1;
                            result.scan_done = 1'b1;
                            result.status    = tlvs_pkg::ST_TOO_LONG;
                        end else if (rec_type == search_type) begin
                            if (value_end > tlvs_pkg::SUM_W'(tlvs_pkg::IMAGE_BYTES)) begin
                                phase_next       = tlvs_pkg::PH_DONE;
                                result.valid     = 1'b1;
                                result.scan_done = 1'b1;
                                result.status    = tlvs_pkg::ST_PAST_END;
                            end else if (len_short == '0) begin
                                phase_next       = tlvs_pkg::PH_DONE;
                                result.valid     = 1'b1;
                                result.scan_done = 1'b1;
                                result.status    = tlvs_pkg::ST_FOUND;
                            end else begin
                                left_next  = len_short;
                                phase_next = tlvs_pkg::PH_VALUE;
                            end
                        end else if (next_end > tlvs_pkg::SUM_W'(tlvs_pkg::IMAGE_BYTES)) begin
                            phase_next       = tlvs_pkg::PH_DONE;
                            result.valid     = 1'b1;
                            result.scan_done = 1'b1;
                            result.status    = tlvs_pkg::ST_NOT_FOUND;
                        end else if (len_short != '0) begin
                            left_next  = len_short;
                            phase_next = tlvs_pkg::PH_SKIP;
                        end
                    end
                end
                tlvs_pkg::PH_SKIP: begin
                    pos_next  = pos_cur + tlvs_pkg::POS_W'(1);
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = tlvs_pkg::PH_HEADER;
                    end
                end
                tlvs_pkg::PH_VALUE: begin
                    pos_next           = pos_cur + tlvs_pkg::POS_W'(1);
                    left_next          = left_dec;
                    result.valid       = 1'b1;
                    result.value       = in_byte;
                    result.value_valid = 1'b1;
                    if (left_dec == '0) begin
                        phase_next       = tlvs_pkg::PH_DONE;
                        result.scan_done = 1'b1;
                        result.status    = tlvs_pkg::ST_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tlvs_pkg::PH_IDLE;
            pos_reg   <= '0;
            hdr_reg   <= '0;
            left_reg  <= '0;
            hcnt_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            left_reg  <= left_next;
            hcnt_reg  <= hcnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tlv_record_search.sv =====
// ----------------------------------------------------------------------------
// TLV record search
// Scans a streamed EEPROM image for the first record of a given type and
// streams out that record's value bytes, ending each scan with a verdict.
//
// The s_ channel takes one image byte per request in tdata; tuser set marks
// byte 0 of an image and restarts the scan at any time. The m_ channel gives
// one request per value byte of the matching record, with tuser bit 0 set.
// The request ending the scan (the last value byte's, or its own if none)
// has tlast set and its tuser status field holds the verdict (found, not
// found, length too large, runs past end). Bytes seen after the verdict give
// nothing until the next marked first byte. A byte is parsed from the input
// register and its result, if any, is offered from the output register the
// cycle after. While the receiver keeps up, one byte is taken every cycle,
// the registers and the parser each passing one byte per cycle; when it
// stalls, the output register holds, the parser waits and the input register
// fills, then s_tready drops. Reset clears the scan to idle, empties both
// registers and sets the search type to zero. The user must write the search
// type by cfg_wr_en only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlv_record_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] image_byte
    input  wire logic        s_tuser,   // [0] first_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] value_out
    output logic [3:0]       m_tuser,   // [0] value_valid, [3:1] status
    output logic             m_tlast    // scan_done
);

    logic [15:0]       search_type_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_first_reg;
    logic              out_valid_reg;
    logic [7:0]        out_value_reg;
    logic              out_vvalid_reg;
    logic              out_done_reg;
    logic [2:0]        out_status_reg;
    logic              step;
    tlvs_pkg::result_t result;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            search_type_reg <= '0;
        end else if (cfg_wr_en) begin
            search_type_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    tlvs_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .search_type (search_type_reg),
        .step        (step),
        .in_byte     (in_byte_reg),
        .in_first    (in_first_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && result.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            out_value_reg  <= result.value;
            out_vvalid_reg <= result.value_valid;
            out_done_reg   <= result.scan_done;
            out_status_reg <= result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_status_reg, out_vvalid_reg};
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire
